[design/zsthin_pkg.sv]
package zsthin_pkg;

  // Default and limits of the image geometry.
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;

  // Configuration register widths and port sizes.
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_STEP     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // Request type codes.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Neighbour sum bounds for a deletable pixel.
  localparam logic [3:0] SUM_LOW  = 4'd2;
  localparam logic [3:0] SUM_HIGH = 4'd6;

  // Per-item control that travels from the accept stage to the window stage.
  typedef struct packed {
    logic pixel;
    logic emit;
    logic interior;
    logic last;
  } s1_flags_t;

  // One result item.
  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic frame_last;
    logic any_removed;
  } result_t;

endpackage

[design/zsthin_line_store.sv]
module zsthin_line_store #(
  parameter int unsigned MAX_WIDTH = zsthin_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  output logic                         rd_top_o,
  output logic                         rd_mid_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic                         wr_top_i,
  input  logic                         wr_mid_i
);
  import zsthin_pkg::*;

  // Pixel two rows above and one row above, per column.
  logic older_mem [MAX_WIDTH];
  logic newer_mem [MAX_WIDTH];

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_top_o <= older_mem[rd_addr_i];
      rd_mid_o <= newer_mem[rd_addr_i];
    end
  end

  // Write port: the column shifts down by one row.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= wr_top_i;
      newer_mem[wr_addr_i] <= wr_mid_i;
    end
  end

endmodule

[design/zsthin_window_eval.sv]
module zsthin_window_eval (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  sub_step_i,
  input  logic                  s1_valid_i,
  input  zsthin_pkg::s1_flags_t s1_flags_i,
  input  logic                  rd_top_i,
  input  logic                  rd_mid_i,
  output logic                  res_valid_o,
  output zsthin_pkg::result_t   res_o
);
  import zsthin_pkg::*;

  logic [8:0] window_q, window_d;
  logic       removal_seen_q, removal_seen_d;
  logic [8:0] win_next;
  logic       center;
  logic       del;
  logic       rem;

  // Decide deletion from the unmodified 3x3 neighbourhood.
  function automatic logic deletable(input logic [8:0] w, input logic step);
    logic [7:0] ring;
    logic [7:0] rise;
    logic [3:0] sum;
    logic [3:0] trans;
    logic       c;
    logic       d;
    // Clockwise from the upper neighbour: P2 P3 P4 P5 P6 P7 P8 P9.
    ring  = {w[0], w[3], w[6], w[7], w[8], w[5], w[2], w[1]};
    sum   = '0;
    trans = '0;
    for (int k = 0; k < 8; k++) begin
      rise[k] = !ring[k] && ring[(k + 1) % 8];
    end
    for (int k = 0; k < 8; k++) begin
      sum   = sum + 4'(ring[k]);
      trans = trans + 4'(rise[k]);
    end
    if (!step) begin
      c = ring[0] & ring[2] & ring[4];
      d = ring[2] & ring[4] & ring[6];
    end else begin
      c = ring[0] & ring[2] & ring[6];
      d = ring[0] & ring[4] & ring[6];
    end
    return (trans == 4'd1) && (sum >= SUM_LOW) && (sum <= SUM_HIGH) && !c && !d;
  endfunction

  // Shift the window left; the new column enters on the right.
  assign win_next = ((window_q >> 1) & 9'h0DB) | {s1_flags_i.pixel, 2'b00, rd_mid_i, 2'b00,
                                                   rd_top_i, 2'b00};
  assign center   = win_next[4];
  assign del      = deletable(win_next, sub_step_i);
  assign rem      = s1_flags_i.emit && s1_flags_i.interior && center && del;

  // Result of the current item.
  assign res_valid_o       = s1_valid_i && s1_flags_i.emit;
  assign res_o.pixel_out   = center & ~rem;
  assign res_o.removed     = rem;
  assign res_o.frame_last  = s1_flags_i.last;
  assign res_o.any_removed = s1_flags_i.last & (removal_seen_q | rem);

  // Window and removal flag; both return to zero at the end of the frame and on a clear.
  always_comb begin
    window_d       = window_q;
    removal_seen_d = removal_seen_q;
    if (clear_i) begin
      window_d       = '0;
      removal_seen_d = 1'b0;
    end else if (s1_valid_i) begin
      if (s1_flags_i.last) begin
        window_d       = '0;
        removal_seen_d = 1'b0;
      end else begin
        window_d       = win_next;
        removal_seen_d = removal_seen_q | rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q       <= '0;
      removal_seen_q <= 1'b0;
    end else begin
      window_q       <= window_d;
      removal_seen_q <= removal_seen_d;
    end
  end

endmodule

[design/zsthin_out_fifo.sv]
module zsthin_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  zsthin_pkg::result_t push_data_i,
  input  logic                pop_i,
  output logic                head_valid_o,
  output zsthin_pkg::result_t head_o,
  output logic [1:0]          count_o
);
  import zsthin_pkg::*;

  result_t    entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = entry_q[rd_ptr_q];
  assign count_o      = count_q;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/zhang_suen_thinning_pass_core.sv]
// One Zhang-Suen thinning sub-iteration over a binary image in raster order.
// Input channel (in_valid_i / in_stall_o): one item per transfer, either a
// pixel or a drain item. After the whole image has been sent, send width+1
// drain items to push out the last row; the final result has frame_last_o
// set and any_removed_o tells whether any pixel was deleted in the pass.
// Output channel (out_valid_o / out_stall_i): one result per pixel, in
// raster order, starting after the first width+1 pixel items.
// Throughput is one item per cycle while in_stall_o is low, set by the single
// read and single write port of the line store, which is read at the accept
// edge and written back in the following cycle. A result is registered in the
// line store read stage, then held in the output queue before it is presented.
// A two-entry output queue lets input continue while a result waits; when
// the receiver stalls, in_stall_o rises as soon as the queue could overflow.
// Reset returns geometry to 640 x 480, sub-step 0, and clears the frame
// counters and window; the line store needs no clearing. A configuration
// write to a known index aborts the frame in progress.
module zhang_suen_thinning_pass_core #(
  parameter int unsigned MAX_WIDTH = zsthin_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic                                pixel_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                pixel_out_o,
  output logic                                removed_o,
  output logic                                frame_last_o,
  output logic                                any_removed_o,
  input  logic                                cfg_we_i,
  input  logic [zsthin_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [zsthin_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import zsthin_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
  localparam int unsigned HW = HEIGHT_REG_W;

  // Configuration registers.
  logic [WIDTH_REG_W-1:0] width_q;
  logic [HW-1:0]          height_q;
  logic                   sub_step_q;
  logic                   cfg_hit;

  // Frame position and accept stage.
  logic [AW-1:0] col_q;
  logic [HW-1:0] row_q;
  logic [CW-1:0] width_ext;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          accept;
  logic          ignored;
  logic          take;
  logic [AW-1:0] col_eff;
  logic [AW-1:0] col_nx;
  logic [HW-1:0] row_nx;
  logic [AW-1:0] nc;
  logic [HW-1:0] nr;
  logic [HW-1:0] cr;
  logic [WW-1:0] cc;
  logic          pixel;
  s1_flags_t     flags;

  // Window stage.
  logic          s1_valid_q;
  logic [AW-1:0] s1_col_q;
  s1_flags_t     s1_flags_q;
  logic          rd_top;
  logic          rd_mid;
  logic          res_valid;
  result_t       res;

  // Output queue.
  result_t       head;
  logic [1:0]    q_count;
  logic          pop;

  // Configuration writes; known indexes abort the frame.
  always_comb begin
    case (cfg_index_i)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_SUB_STEP: cfg_hit = cfg_we_i;
      default:                                        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      sub_step_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q    <= cfg_wdata_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q   <= cfg_wdata_i[HW-1:0];
        REG_SUB_STEP:     sub_step_q <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  // Saturated geometry.
  always_comb begin
    width_ext = CW'(width_q);
    if (width_ext < CW'(3)) begin
      width_ext = CW'(3);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_ext = CW'(MAX_WIDTH);
    end
    w_eff = WW'(width_ext);
    h_eff = height_q;
    if (h_eff < HW'(3)) begin
      h_eff = HW'(3);
    end else if (h_eff > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end
  end

  // Handshakes. Stall when the queue could not take this item's result.
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = (3'(q_count) + 3'(res_valid)) > (3'(pop) + 3'd1);
  assign accept     = in_valid_i && !in_stall_o;

  // Accept stage: drop early drains and surplus pixels, advance the position.
  always_comb begin
    pixel   = (req_type_i == REQ_DRAIN) ? 1'b0 : pixel_in_i;
    ignored = (req_type_i == REQ_DRAIN) ? (row_q < h_eff) : (row_q >= h_eff);
    take    = accept && !ignored;
    col_eff = (WW'(col_q) >= w_eff) ? '0 : col_q;
    if ((WW'(col_eff) + WW'(1)) >= w_eff) begin
      nc = '0;
      nr = row_q + HW'(1);
    end else begin
      nc = col_eff + AW'(1);
      nr = row_q;
    end
    // Position of the window center in the image.
    cr = (nc == '0) ? (nr - HW'(1)) : nr;
    cc = (nc == '0) ? w_eff : WW'(nc);
    flags.pixel    = pixel;
    flags.emit     = (row_q >= HW'(2)) || ((row_q == HW'(1)) && (col_eff != '0));
    flags.interior = (nr >= HW'(2)) && (nr <= (h_eff - HW'(1))) && (nc != AW'(1)) &&
                     (cr >= HW'(2)) && (cr <= (h_eff - HW'(1))) && (cc >= WW'(3));
    flags.last     = (row_q == (h_eff + HW'(1))) && (col_eff == '0);
    col_nx = flags.last ? '0 : nc;
    row_nx = flags.last ? '0 : nr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else if (cfg_hit) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (take) begin
        col_q <= col_nx;
        row_q <= row_nx;
      end
      s1_valid_q <= take;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_col_q   <= col_eff;
      s1_flags_q <= flags;
    end
  end

  zsthin_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (take),
    .rd_addr_i (col_eff),
    .rd_top_o  (rd_top),
    .rd_mid_o  (rd_mid),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_top_i  (rd_mid),
    .wr_mid_i  (s1_flags_q.pixel)
  );

  zsthin_window_eval u_window_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_hit),
    .sub_step_i  (sub_step_q),
    .s1_valid_i  (s1_valid_q),
    .s1_flags_i  (s1_flags_q),
    .rd_top_i    (rd_top),
    .rd_mid_i    (rd_mid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  zsthin_out_fifo u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_data_i  (res),
    .pop_i        (pop),
    .head_valid_o (out_valid_o),
    .head_o       (head),
    .count_o      (q_count)
  );

  assign pixel_out_o   = head.pixel_out;
  assign removed_o     = head.removed;
  assign frame_last_o  = head.frame_last;
  assign any_removed_o = head.any_removed;

endmodule
